>>> rtl/pzcsa_pkg.sv
`timescale 1ns / 1ps

package pzcsa_pkg;

  // sample counts of the start-up phases
  localparam int IDLE_TICKS = 40;
  localparam int CAL_TICKS  = 40;
  localparam int TOTAL_TICKS = IDLE_TICKS + CAL_TICKS;

  // field and state widths
  localparam int SAMPLE_W = 16;
  localparam int TICK_W   = 7;
  localparam int SUM_W    = 22;
  localparam int ROOT_W   = 16;

  // rounded mean: (2 * sum + CAL_TICKS) / (2 * CAL_TICKS)
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN     = 2 * CAL_TICKS;
  localparam int DREM_W  = (DEN > 2) ? $clog2(DEN) : 1;
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam logic [DREM_W:0] DEN_C = (DREM_W + 1)'(DEN);

  // root: radicand is the difference shifted up by 16, two bits a step
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SREM_W  = ROOT_W + 1;
  localparam int SCNT_W  = $clog2(ROOT_W);

  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [NUM_W-1:0]    numer_t;

  typedef enum logic [1:0] {
    STATUS_DISCONNECTED = 2'd0,
    STATUS_CALIBRATING  = 2'd1,
    STATUS_VALID        = 2'd2
  } status_t;

endpackage

>>> rtl/pzcsa_if.sv
`timescale 1ns / 1ps

// input channel: one sensor reading per item
interface pzcsa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        sample_valid;
  logic [pzcsa_pkg::SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output sample_valid, output raw_sample, input ready);
  modport sink   (input valid, input sample_valid, input raw_sample, output ready);
endinterface

// output channel: status, airspeed and zero point per item
interface pzcsa_out_if;
  logic                         valid;
  logic                         ready;
  pzcsa_pkg::status_t           status;
  logic [pzcsa_pkg::ROOT_W-1:0]   airspeed;
  logic [pzcsa_pkg::SAMPLE_W-1:0] zero_point_out;

  modport source (output valid, output status, output airspeed, output zero_point_out,
                  input ready);
  modport sink   (input valid, input status, input airspeed, input zero_point_out,
                  output ready);
endinterface

>>> rtl/pitot_zero_calibrate_sqrt_airspeed_unit.sv
// path: failed reads and start-up samples go through the hold state to the output register,
// an airspeed item first runs the two-bit-a-step root loop, and the last
// calibration sample runs the serial mean divider first and then the root loop
// throughput: one item in flight; the next is taken once the result is queued
// reset: synchronous, clears counters, sum and zero point to 0, no item pending
`timescale 1ns / 1ps

module pitot_zero_calibrate_sqrt_airspeed_unit (
  input  logic        clk,
  input  logic        rst,
  pzcsa_in_if.sink    sample,
  pzcsa_out_if.source result
);
  import pzcsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_HOLD
  } state_t;

  state_t  state;
  tick_t   tick_count;
  sum_t    sample_sum;
  sample_t zero_point;
  sample_t held;
  sum_t    sum_add;
  numer_t  div_numer;
  sample_t root_op;

  logic    div_start;
  logic    div_done;
  sample_t div_quot;
  logic    root_start;
  logic    root_done;
  logic [ROOT_W-1:0] root_val;

  status_t res_status;
  logic [ROOT_W-1:0] res_speed;
  sample_t res_zero;

  logic    out_valid;
  status_t out_status;
  logic [ROOT_W-1:0] out_speed;
  sample_t out_zero;

  // running sum and operands of the serial units
  always_comb begin
    sum_add   = sample_sum + SUM_W'(sample.raw_sample);
    div_numer = {sample_sum, 1'b0} + NUM_W'(CAL_TICKS);
    root_op   = (held > zero_point) ? (held - zero_point) : '0;
  end

  pzcsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .done  (div_done),
    .quot  (div_quot)
  );

  pzcsa_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (root_op),
    .done    (root_done),
    .root    (root_val)
  );

  assign sample.ready          = (state == ST_IDLE);
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.airspeed       = out_speed;
  assign result.zero_point_out = out_zero;

  // sequencer, calibration state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      sample_sum <= '0;
      zero_point <= '0;
      div_start  <= 1'b0;
      root_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      div_start  <= 1'b0;
      root_start <= 1'b0;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            res_speed <= '0;
            res_zero  <= zero_point;
            held      <= sample.raw_sample;
            if (!sample.sample_valid) begin
              res_status <= STATUS_DISCONNECTED;
              state      <= ST_HOLD;
            end else if (tick_count < TICK_W'(IDLE_TICKS)) begin
              tick_count <= tick_count + 1'b1;
              sample_sum <= '0;
              res_status <= STATUS_CALIBRATING;
              state      <= ST_HOLD;
            end else if (tick_count < TICK_W'(TOTAL_TICKS)) begin
              tick_count <= tick_count + 1'b1;
              sample_sum <= sum_add;
              if (tick_count == TICK_W'(TOTAL_TICKS - 1)) begin
                div_start <= 1'b1;
                state     <= ST_DIV;
              end else begin
                res_status <= STATUS_CALIBRATING;
                state      <= ST_HOLD;
              end
            end else begin
              root_start <= 1'b1;
              state      <= ST_ROOT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            zero_point <= div_quot;
            root_start <= 1'b1;
            state      <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            res_status <= STATUS_VALID;
            res_speed  <= root_val;
            res_zero   <= zero_point;
            state      <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_speed  <= res_speed;
            out_zero   <= res_zero;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    tick_count <= TICK_W'(TOTAL_TICKS))
    else $error("tick count beyond end of calibration");

  a_zero_before_cal: assert property (@(posedge clk) disable iff (rst)
    (tick_count < TICK_W'(TOTAL_TICKS)) |-> (zero_point == '0))
    else $error("zero point set before calibration ended");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  a_root_done_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == ST_ROOT))
    else $error("root unit finished outside its wait state");

endmodule

>>> rtl/pzcsa_div.sv
`timescale 1ns / 1ps

module pzcsa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  pzcsa_pkg::numer_t           numer,
  output logic                        done,
  output logic [pzcsa_pkg::SAMPLE_W-1:0] quot
);
  import pzcsa_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  numer_t            num;
  logic [DREM_W-1:0] rem;
  logic [DREM_W:0]   acc;
  logic              ge;
  logic [DREM_W:0]   acc_sub;

  // one quotient bit a cycle, restoring against the fixed divisor
  always_comb begin
    acc     = {rem, num[NUM_W-1]};
    ge      = (acc >= DEN_C);
    acc_sub = acc - DEN_C;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // shift registers of numerator, remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      num <= numer;
      rem <= '0;
    end else if (busy) begin
      num  <= {num[NUM_W-2:0], 1'b0};
      rem  <= ge ? acc_sub[DREM_W-1:0] : acc[DREM_W-1:0];
      quot <= {quot[SAMPLE_W-2:0], ge};
    end
  end

endmodule

>>> rtl/pzcsa_sqrt.sv
`timescale 1ns / 1ps

module pzcsa_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  pzcsa_pkg::sample_t          operand,
  output logic                        done,
  output logic [pzcsa_pkg::ROOT_W-1:0] root
);
  import pzcsa_pkg::*;

  logic              busy;
  logic [SCNT_W-1:0] cnt;
  logic [RAD_W-1:0]  rad;
  logic [SREM_W-1:0] rem;
  logic [SREM_W+1:0] acc;
  logic [SREM_W+1:0] trial;
  logic              ge;
  logic [SREM_W+1:0] acc_sub;

  // one root bit a cycle from the next two radicand bits
  always_comb begin
    acc     = {rem, rad[RAD_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    ge      = (acc >= trial);
    acc_sub = acc - trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SCNT_W'(ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // radicand, partial remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {operand, {(RAD_W - SAMPLE_W){1'b0}}};
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? acc_sub[SREM_W-1:0] : acc[SREM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule
